@@ rtl/bpa_pkg.sv @@
// ============================================================================
// bpa_pkg: shared types and codes of the bitmap page allocator
// Request and result items, operation codes and status codes.
// ============================================================================
package bpa_pkg;

    // Width of the block count register and of the used count.
    localparam int COUNT_W = 16;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;
    localparam logic [1:0] OP_TEST    = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_NOFREE = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    // One request item.
    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        byte_address;
        logic [COUNT_W-1:0] block_index;
    } request_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        result_address;
        logic               block_used;
        logic [COUNT_W-1:0] used_count;
    } result_t;

endpackage

@@ rtl/bpa_ram.sv @@
// ============================================================================
// bpa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bpa_ctrl.sv @@
// ============================================================================
// bpa_ctrl: sequencer of the bitmap page allocator
// Sweeps the map to all ones, then serves each accepted item by reading its
// word and writing it back where a bit changes, scanning upward from a hint word on allocate.
// ============================================================================
module bpa_ctrl #(
    parameter int BLOCK_LIMIT = 32768,
    parameter int WORD_BITS   = 32,
    parameter int BLOCK_SHIFT = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               reinit,
    input  logic [bpa_pkg::COUNT_W-1:0]        block_count,
    input  logic                               start,
    input  bpa_pkg::request_t                  request,
    output logic                               busy,
    output logic                               done,
    output bpa_pkg::result_t                   result,
    output logic                               ram_we,
    output logic [(((BLOCK_LIMIT + WORD_BITS - 1) / WORD_BITS) > 1 ?
                   $clog2((BLOCK_LIMIT + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] ram_waddr,
    output logic [WORD_BITS-1:0]               ram_wdata,
    output logic [(((BLOCK_LIMIT + WORD_BITS - 1) / WORD_BITS) > 1 ?
                   $clog2((BLOCK_LIMIT + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] ram_raddr,
    input  logic [WORD_BITS-1:0]               ram_rdata
);

    // WORD_BITS is a power of two; block numbers split into word and bit.
    localparam int MAP_WORDS = (BLOCK_LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WS        = $clog2(WORD_BITS);
    localparam int CW        = bpa_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST_WORD  = AW'(MAP_WORDS - 1);
    localparam logic [31:0]   ALIGN_MASK = (32'd1 << BLOCK_SHIFT) - 32'd1;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_EVAL
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [CW-1:0]     fc_reg, fc_next;
    logic [AW-1:0]     hint_reg, hint_next;
    logic [1:0]        op_reg, op_next;
    logic [AW-1:0]     word_reg, word_next;
    logic [WS-1:0]     bit_reg, bit_next;
    logic              done_reg, done_next;
    bpa_pkg::result_t  result_reg, result_next;

    logic [31:0]          free_blk;
    logic [31:0]          tgt_blk;
    logic                 in_range;
    logic                 free_ok;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 cur_bit;
    logic                 word_full;
    logic [WS-1:0]        low_pos;
    logic [31:0]          found_blk;

    // Position of the lowest clear bit of a word.
    function automatic logic [WS-1:0] low_zero(input logic [WORD_BITS-1:0] w);
        logic [WS-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = WS'(i);
            end
        end
        return pos;
    endfunction

    // Decode of the incoming request.
    assign free_blk = request.byte_address >> BLOCK_SHIFT;
    assign tgt_blk  = (request.operation == bpa_pkg::OP_FREE) ? free_blk
                                                              : 32'(request.block_index);
    assign in_range = tgt_blk < 32'(block_count);
    assign free_ok  = (request.byte_address != 32'd0) &&
                      ((request.byte_address & ALIGN_MASK) == 32'd0) && in_range;

    // Bit under test in the word just read.
    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    assign cur_bit   = ram_rdata[bit_reg];
    assign word_full = &ram_rdata;
    assign low_pos   = low_zero(ram_rdata);
    assign found_blk = 32'({word_reg, low_pos});

    // Next-state and memory port logic.
    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        fc_next     = fc_reg;
        hint_next   = hint_reg;
        op_next     = op_reg;
        word_next   = word_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = word_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = word_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = '1;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = request.operation;
                    word_next = tgt_blk[WS +: AW];
                    bit_next  = tgt_blk[WS-1:0];
                    result_next.status         = bpa_pkg::STATUS_REJECT;
                    result_next.result_address = 32'd0;
                    result_next.block_used     = 1'b0;
                    if (block_count == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        unique case (request.operation)
                            bpa_pkg::OP_ALLOC:
                            begin
                                if (fc_reg == '0)
                                begin
                                    result_next.status = bpa_pkg::STATUS_NOFREE;
                                    done_next          = 1'b1;
                                end
                                else
                                begin
                                    word_next  = hint_reg;
                                    state_next = S_EVAL;
                                end
                            end
                            bpa_pkg::OP_FREE:
                            begin
                                if (free_ok)
                                begin
                                    state_next = S_EVAL;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                            bpa_pkg::OP_RESERVE,
                            bpa_pkg::OP_TEST:
                            begin
                                if (in_range)
                                begin
                                    state_next = S_EVAL;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        endcase
                        ram_raddr = word_next;
                    end
                end
            end

            S_EVAL:
            begin
                result_next.status = bpa_pkg::STATUS_DONE;
                unique case (op_reg)
                    bpa_pkg::OP_ALLOC:
                    begin
                        if (word_full)
                        begin
                            // Skip a full word and read the next one.
                            word_next = word_reg + AW'(1);
                            ram_raddr = word_next;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | (WORD_BITS'(1) << low_pos);
                            fc_next   = fc_reg - CW'(1);
                            hint_next = word_reg;
                            result_next.result_address = found_blk << BLOCK_SHIFT;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    bpa_pkg::OP_FREE:
                    begin
                        if (cur_bit)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~bit_mask;
                            fc_next   = fc_reg + CW'(1);
                            if (word_reg < hint_reg)
                            begin
                                hint_next = word_reg;
                            end
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    bpa_pkg::OP_RESERVE:
                    begin
                        if (!cur_bit)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | bit_mask;
                            fc_next   = fc_reg - CW'(1);
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    bpa_pkg::OP_TEST:
                    begin
                        result_next.block_used = cur_bit;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The used count goes out with every result item.
        if (done_next)
        begin
            result_next.used_count = block_count - fc_next;
        end

        // A register write reinitialises the whole map.
        if (reinit)
        begin
            state_next = S_SWEEP;
            sweep_next = '0;
            fc_next    = '0;
            hint_next  = '0;
            done_next  = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            sweep_reg  <= '0;
            fc_reg     <= '0;
            hint_reg   <= '0;
            op_reg     <= bpa_pkg::OP_ALLOC;
            word_reg   <= '0;
            bit_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            fc_reg     <= fc_next;
            hint_reg   <= hint_next;
            op_reg     <= op_next;
            word_reg   <= word_next;
            bit_reg    <= bit_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The free count never exceeds the number of managed blocks.
    assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= block_count)
        else $error("free count above block count");

    // An allocate scan only runs while some block is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && op_reg == bpa_pkg::OP_ALLOC) |-> (fc_reg != '0))
        else $error("allocate scan with no free block");

    // The block handed out always lies below the block count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && op_reg == bpa_pkg::OP_ALLOC && !word_full)
            |-> (found_blk < 32'(block_count)))
        else $error("allocated block beyond block count");

    // Every word below the hint is full, so the scan never starts above the word it reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && op_reg == bpa_pkg::OP_ALLOC) |-> (hint_reg <= word_reg))
        else $error("allocate scan below the hint word");

endmodule

@@ rtl/bitmap_page_allocator.sv @@
// ============================================================================
// bitmap_page_allocator: first-fit page-frame allocator over a used bitmap
// One used bit per block, packed into words of a single RAM. Items allocate,
// free, reserve or test blocks; a kept free count gives the used count.
// ============================================================================
//
//  Channel   Ports                        Direction  Handshake
//  --------  ---------------------------  ---------  ------------------------
//  request   start, busy, request         in         taken when start && !busy
//  result    done, result                 out        valid for the one cycle
//                                                     that done is high
//  config    cfg_write, cfg_data          in         written when cfg_write
//
//  A rejected or no-free item gives its result in the cycle after it is taken.
//  Other items read the map word, then update it and write it back where a
//  bit changes; an allocate first skips each full word from its hint up.
//  After reset, and after each write of the block count, the map is swept to
//  all ones, one word a cycle, with busy high. The result side cannot stall;
//  busy is low again in the cycle that done is high, so the next item may be
//  taken there.
//
module bitmap_page_allocator #(
    parameter int BLOCK_LIMIT = 32768,
    parameter int WORD_BITS   = 32,
    parameter int BLOCK_SHIFT = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [bpa_pkg::COUNT_W-1:0] cfg_data,
    input  logic                        start,
    input  bpa_pkg::request_t           request,
    output logic                        busy,
    output logic                        done,
    output bpa_pkg::result_t            result
);

    localparam int MAP_WORDS = (BLOCK_LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [bpa_pkg::COUNT_W-1:0] block_count_reg, block_count_next;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    logic [WORD_BITS-1:0]        ram_wdata;
    logic [WORD_BITS-1:0]        ram_rdata;

    // Block count register, saturated to the size of the map.
    always_comb
    begin
        block_count_next = block_count_reg;
        if (cfg_write)
        begin
            if (32'(cfg_data) > 32'(BLOCK_LIMIT))
            begin
                block_count_next = bpa_pkg::COUNT_W'(BLOCK_LIMIT);
            end
            else
            begin
                block_count_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
        end
        else
        begin
            block_count_reg <= block_count_next;
        end
    end

    // Used bitmap.
    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer.
    bpa_ctrl #(
        .BLOCK_LIMIT (BLOCK_LIMIT),
        .WORD_BITS   (WORD_BITS),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .reinit      (cfg_write),
        .block_count (block_count_reg),
        .start       (start),
        .request     (request),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

endmodule

@@ tb/bitmap_page_allocator_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// bitmap_page_allocator_tb: self-checking bench for the bitmap page allocator
// Drives allocate, free, reserve and test items through the start/busy port
// under several block counts, with random gaps between items in some runs.
// It keeps its own copy of the used bitmap and the free count, works out
// the result of every accepted item, and compares each strobed result with
// the oldest outstanding prediction.
// ============================================================================
module bitmap_page_allocator_tb;

    localparam int BLOCK_LIMIT = 32768;
    localparam int WORD_BITS   = 32;
    localparam int BLOCK_SHIFT = 12;
    localparam int MAP_WORDS   = (BLOCK_LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam int COUNT_W     = bpa_pkg::COUNT_W;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [COUNT_W-1:0] cfg_data;
    logic               start;
    bpa_pkg::request_t  request;
    logic               busy;
    logic               done;
    bpa_pkg::result_t   result;

    // Bench copy of the allocator state.
    logic [WORD_BITS-1:0] used_words [MAP_WORDS];
    int unsigned          managed_blocks;
    int unsigned          free_blocks;

    bpa_pkg::result_t outstanding_results [$];
    bpa_pkg::result_t oldest_result;
    int unsigned      mismatches;
    int unsigned      stall_cycles;
    bit               no_gaps;

    bitmap_page_allocator #(
        .BLOCK_LIMIT (BLOCK_LIMIT),
        .WORD_BITS   (WORD_BITS),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Bitmap prediction
    // ------------------------------------------------------------------------

    // Every block is marked used and nothing is counted free.
    function automatic void fill_bitmap();
        for (int w = 0; w < MAP_WORDS; w++)
            used_words[w] = '1;
        free_blocks = 0;
    endfunction

    function automatic void set_block_count(logic [COUNT_W-1:0] value);
        managed_blocks = (32'(value) > BLOCK_LIMIT) ? BLOCK_LIMIT : 32'(value);
        fill_bitmap();
    endfunction

    function automatic bit block_is_used(int unsigned blk);
        return used_words[blk / WORD_BITS][blk % WORD_BITS];
    endfunction

    function automatic void mark_used(int unsigned blk);
        if (!block_is_used(blk))
        begin
            used_words[blk / WORD_BITS][blk % WORD_BITS] = 1'b1;
            free_blocks--;
        end
    endfunction

    function automatic void mark_free(int unsigned blk);
        if (block_is_used(blk))
        begin
            used_words[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
            free_blocks++;
        end
    endfunction

    // Lowest free block below the block count, including the partial last
    // word; the block count itself when the map is full.
    function automatic int unsigned lowest_free_block();
        int unsigned words;
        int unsigned blk;
        words = (managed_blocks + WORD_BITS - 1) / WORD_BITS;
        for (int unsigned w = 0; w < words; w++)
        begin
            if (used_words[w] != '1)
            begin
                for (int unsigned j = 0; j < WORD_BITS; j++)
                begin
                    blk = w * WORD_BITS + j;
                    if (!used_words[w][j] && blk < managed_blocks)
                        return blk;
                end
            end
        end
        return managed_blocks;
    endfunction

    // Applies one item to the bench bitmap and returns the result it should give.
    function automatic bpa_pkg::result_t allocator_outcome(bpa_pkg::request_t req);
        bpa_pkg::result_t res;
        int unsigned      blk;
        res        = '0;
        res.status = bpa_pkg::STATUS_REJECT;
        if (managed_blocks != 0)
        begin
            case (req.operation)
                bpa_pkg::OP_ALLOC:
                begin
                    blk = lowest_free_block();
                    if (blk < managed_blocks)
                    begin
                        mark_used(blk);
                        res.result_address = 32'(blk << BLOCK_SHIFT);
                        res.status         = bpa_pkg::STATUS_DONE;
                    end
                    else
                    begin
                        res.status = bpa_pkg::STATUS_NOFREE;
                    end
                end
                bpa_pkg::OP_FREE:
                begin
                    blk = req.byte_address >> BLOCK_SHIFT;
                    if (req.byte_address != 0 && req.byte_address[BLOCK_SHIFT-1:0] == '0
                        && blk < managed_blocks)
                    begin
                        mark_free(blk);
                        res.status = bpa_pkg::STATUS_DONE;
                    end
                end
                bpa_pkg::OP_RESERVE:
                begin
                    if (32'(req.block_index) < managed_blocks)
                    begin
                        mark_used(32'(req.block_index));
                        res.status = bpa_pkg::STATUS_DONE;
                    end
                end
                bpa_pkg::OP_TEST:
                begin
                    if (32'(req.block_index) < managed_blocks)
                    begin
                        res.block_used = block_is_used(32'(req.block_index));
                        res.status     = bpa_pkg::STATUS_DONE;
                    end
                end
            endcase
        end
        res.used_count = COUNT_W'(managed_blocks - free_blocks);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------------

    function automatic bpa_pkg::request_t make_request(logic [1:0] op, logic [31:0] addr,
                                                       logic [COUNT_W-1:0] idx);
        bpa_pkg::request_t req;
        req.operation    = op;
        req.byte_address = addr;
        req.block_index  = idx;
        return req;
    endfunction

    // Mostly well-formed items aimed at blocks in range, with some noise:
    // aligned addresses beyond the map, misaligned addresses and raw values.
    function automatic bpa_pkg::request_t random_request();
        bpa_pkg::request_t req;
        int unsigned       pick;
        int unsigned       blk;
        req.byte_address = $urandom();
        req.block_index  = COUNT_W'($urandom_range(0, 16'hFFFF));
        pick = $urandom_range(0, 99);
        if (pick < 35)
            req.operation = bpa_pkg::OP_ALLOC;
        else if (pick < 70)
            req.operation = bpa_pkg::OP_FREE;
        else if (pick < 85)
            req.operation = bpa_pkg::OP_RESERVE;
        else
            req.operation = bpa_pkg::OP_TEST;
        pick = $urandom_range(0, 99);
        blk  = (managed_blocks != 0) ? $urandom_range(0, managed_blocks - 1) : 0;
        if (pick < 80)
        begin
            req.block_index  = COUNT_W'(blk);
            if (req.operation == bpa_pkg::OP_FREE)
                req.byte_address = 32'(blk) << BLOCK_SHIFT;
        end
        else if (pick < 90)
        begin
            req.byte_address = 32'($urandom_range(0, 16'hFFFF)) << BLOCK_SHIFT;
        end
        else if (pick < 95)
        begin
            req.byte_address = (32'(blk) << BLOCK_SHIFT) | 32'($urandom_range(1, 4095));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Port driving
    // ------------------------------------------------------------------------

    // Presents one item after a random gap and returns at the edge that takes
    // it. The caller must act at the very next falling edge, since start is
    // still high.
    task automatic send_item(input bpa_pkg::request_t item);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= item;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        outstanding_results.push_back(allocator_outcome(item));
    endtask

    task automatic stop_requests();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (outstanding_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the block count once the allocator is idle, then waits until busy
    // shows the sweep that the write starts.
    task automatic write_block_count(input logic [COUNT_W-1:0] value);
        stop_requests();
        wait_for_results();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        set_block_count(value);
        @(negedge clk);
        cfg_write <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (busy)
                break;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // With no block count written every operation is refused.
    task automatic check_uninitialised_requests();
        send_item(make_request(bpa_pkg::OP_ALLOC, 32'h0000_0000, 16'h0000));
        send_item(make_request(bpa_pkg::OP_FREE, 32'h0000_1000, 16'h0000));
        send_item(make_request(bpa_pkg::OP_RESERVE, 32'hFFFF_FFFF, 16'h0000));
        send_item(make_request(bpa_pkg::OP_TEST, 32'h0000_0000, 16'h0001));
    endtask

    // Forty blocks, so the last word is only partly managed. Block zero can
    // never be freed, since a zero address is refused.
    task automatic check_edge_cases();
        write_block_count(16'd40);
        send_item(make_request(bpa_pkg::OP_ALLOC, 32'h0, 16'h0));
        send_item(make_request(bpa_pkg::OP_FREE, 32'h0000_0000, 16'h0));
        send_item(make_request(bpa_pkg::OP_FREE, 32'h0000_1001, 16'h0));
        send_item(make_request(bpa_pkg::OP_FREE, 32'd40 << BLOCK_SHIFT, 16'h0));
        send_item(make_request(bpa_pkg::OP_FREE, 32'd5 << BLOCK_SHIFT, 16'h0));
        send_item(make_request(bpa_pkg::OP_FREE, 32'd5 << BLOCK_SHIFT, 16'h0));
        send_item(make_request(bpa_pkg::OP_FREE, 32'd39 << BLOCK_SHIFT, 16'h0));
        send_item(make_request(bpa_pkg::OP_TEST, 32'h0, 16'd39));
        send_item(make_request(bpa_pkg::OP_TEST, 32'h0, 16'd40));
        send_item(make_request(bpa_pkg::OP_TEST, 32'h0, 16'hFFFF));
        send_item(make_request(bpa_pkg::OP_RESERVE, 32'h0, 16'hFFFF));
        send_item(make_request(bpa_pkg::OP_ALLOC, 32'h0, 16'h0));
        send_item(make_request(bpa_pkg::OP_ALLOC, 32'h0, 16'h0));
        send_item(make_request(bpa_pkg::OP_ALLOC, 32'h0, 16'h0));
        send_item(make_request(bpa_pkg::OP_RESERVE, 32'h0, 16'd7));
        send_item(make_request(bpa_pkg::OP_FREE, 32'd7 << BLOCK_SHIFT, 16'h0));
        send_item(make_request(bpa_pkg::OP_RESERVE, 32'h0, 16'd7));
        send_item(make_request(bpa_pkg::OP_TEST, 32'h0, 16'd7));
        send_item(make_request(bpa_pkg::OP_FREE, 32'hFFFF_F000, 16'h0));
    endtask

    task automatic run_random_traffic(input logic [COUNT_W-1:0] value,
                                      input int unsigned count, input bit back_to_back);
        write_block_count(value);
        no_gaps = back_to_back;
        repeat (count) send_item(random_request());
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
            note_mismatch(field, want, got);
    endtask

    // Each strobed result is matched against the oldest outstanding item.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outstanding_results.size() == 0)
            begin
                note_mismatch("unrequested result", 32'h0, 32'(result.status));
            end
            else
            begin
                oldest_result = outstanding_results.pop_front();
                compare_field("status", 32'(oldest_result.status), 32'(result.status));
                compare_field("result_address", oldest_result.result_address,
                              result.result_address);
                compare_field("block_used", 32'(oldest_result.block_used),
                              32'(result.block_used));
                compare_field("used_count", 32'(oldest_result.used_count),
                              32'(result.used_count));
            end
        end
    end

    // Ends a run that stops making progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_data     = '0;
        start        = 1'b0;
        request      = '0;
        no_gaps      = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        set_block_count('0);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_uninitialised_requests();
        check_edge_cases();
        // A count above the maximum saturates; zero leaves the map unusable.
        run_random_traffic(16'hFFFF, 200, 1'b0);
        run_random_traffic(16'd33, 300, 1'b1);
        run_random_traffic(16'd1, 80, 1'b0);
        run_random_traffic(16'd0, 20, 1'b0);
        run_random_traffic(16'd40000, 200, 1'b1);
        run_random_traffic(16'd2, 100, 1'b0);
        run_random_traffic(16'd600, 530, 1'b0);
        run_random_traffic(16'd32768, 200, 1'b0);

        stop_requests();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (outstanding_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
